FILE: rtl/core/ppaj_pkg.sv
package ppaj_pkg;

  localparam int HitEntries = 64;
  localparam int IdxW = $clog2(HitEntries);
  localparam int CntW = $clog2(HitEntries + 1);
  localparam int AddrW = 4;
  localparam int KeyW = 208;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_PRODUCT  = 2'd0,
    STATUS_END      = 2'd1,
    STATUS_BAD_CFG  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_MIN_AMP  = 2'd0,
    REG_MAX_AMP  = 2'd1,
    REG_PLEN_ONE = 2'd2,
    REG_PLEN_TWO = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic        primer;
    logic        strand;
    logic [31:0] pos;
    logic [6:0]  mm;
    logic [63:0] mask;
  } hit_t;

  typedef struct packed {
    logic [31:0] min_amp;
    logic [31:0] max_amp;
    logic [6:0]  plen_one;
    logic [6:0]  plen_two;
  } cfg_t;

  typedef struct packed {
    logic        lp;
    logic        rp;
    logic [31:0] start;
    logic [31:0] len;
    logic [6:0]  lmm;
    logic [6:0]  rmm;
    logic [63:0] lmask;
    logic [63:0] rmask;
    logic [31:0] rpos;
    logic [32:0] amp_end;
  } cand_t;

  // Product order: start, length, primers and mismatch counts, then the two masks.
  function automatic logic [KeyW-1:0] prod_key(input cand_t c);
    prod_key = {c.start, c.len, c.lp, c.rp, c.lmm, c.rmm, c.lmask, c.rmask};
  endfunction

endpackage

FILE: rtl/core/ppaj_ram.sv
module ppaj_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/core/ppaj_pair_unit.sv
module ppaj_pair_unit import ppaj_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  hit_t  fwd_i,
  input  hit_t  rev_i,
  input  cfg_t  cfg_i,
  output logic  valid_o,
  output cand_t cand_o
);

  logic [6:0]  plen_f, plen_r;
  logic [32:0] fpos, rpos, fmin, amp_end, len;
  logic        ok;
  cand_t       cand;

  always_comb begin
    plen_f  = fwd_i.primer ? cfg_i.plen_two : cfg_i.plen_one;
    plen_r  = rev_i.primer ? cfg_i.plen_two : cfg_i.plen_one;
    fpos    = {1'b0, fwd_i.pos};
    rpos    = {1'b0, rev_i.pos};
    fmin    = fpos + 33'(plen_f);
    amp_end = rpos + 33'(plen_r);
    len     = amp_end - fpos;
    ok = !fwd_i.strand && rev_i.strand && (fwd_i.primer != rev_i.primer) &&
         !(rpos < fmin) && (amp_end > fpos) &&
         (len >= {1'b0, cfg_i.min_amp}) && (len <= {1'b0, cfg_i.max_amp});
    cand.lp      = fwd_i.primer;
    cand.rp      = rev_i.primer;
    cand.start   = fwd_i.pos;
    cand.len     = len[31:0];
    cand.lmm     = fwd_i.mm;
    cand.rmm     = rev_i.mm;
    cand.lmask   = fwd_i.mask;
    cand.rmask   = rev_i.mask;
    cand.rpos    = rev_i.pos;
    cand.amp_end = amp_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i && ok;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_o <= cand;
  end

endmodule

FILE: rtl/core/primer_pair_amplicon_join.sv
// Primer pair amplicon join. Hits are loaded with kind load, and clear drops all stored
// hits. A fetch scans every ordered pair of stored hits, one pair per cycle through a
// shared pair evaluation unit fed by two copies of the hit table. Fetches that fail the
// configuration or overflow checks answer in the cycle after the request. Each fetch
// yields exactly one transaction on the result ports, shown for one cycle with done_o
// high; the receiver cannot stall it, so it must take every result.
// Configuration must only be written while busy is low.
module primer_pair_amplicon_join import ppaj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic              hit_primer_i,
  input  logic              hit_strand_i,
  input  logic [31:0]       hit_position_i,
  input  logic [6:0]        hit_mismatches_i,
  input  logic [63:0]       hit_mask_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic              left_primer_o,
  output logic              right_primer_o,
  output logic [31:0]       left_position_o,
  output logic [31:0]       right_position_o,
  output logic [6:0]        left_mismatches_o,
  output logic [6:0]        right_mismatches_o,
  output logic [32:0]       amplicon_end_o,
  output logic [31:0]       amplicon_length_o,
  output logic [63:0]       left_mask_o,
  output logic [63:0]       right_mask_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  cfg_t cfg_q;
  logic cfg_we;
  reg_e reg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign reg_sel = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_amp  <= 32'd1;
      cfg_q.max_amp  <= 32'd1000;
      cfg_q.plen_one <= 7'd20;
      cfg_q.plen_two <= 7'd20;
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_MIN_AMP:  cfg_q.min_amp  <= pwdata;
        REG_MAX_AMP:  cfg_q.max_amp  <= pwdata;
        REG_PLEN_ONE: cfg_q.plen_one <= pwdata[6:0];
        REG_PLEN_TWO: cfg_q.plen_two <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MIN_AMP:  prdata = cfg_q.min_amp;
      REG_MAX_AMP:  prdata = cfg_q.max_amp;
      REG_PLEN_ONE: prdata = {25'd0, cfg_q.plen_one};
      REG_PLEN_TWO: prdata = {25'd0, cfg_q.plen_two};
      default:      prdata = 32'd0;
    endcase
  end

  // Sequencer state.
  state_e          state_q, state_d;
  logic [CntW-1:0] count_q;
  logic            overflow_q;
  logic [IdxW-1:0] fi_q, ri_q, last_idx;
  logic            issue_v, rd_v_q, cand_v;
  logic            accept, fetch_go, scan_step, report;
  logic            bad_cfg;
  kind_e           kind;
  hit_t            new_hit, fwd_hit, rev_hit;
  cand_t           cand, best_q;
  logic            best_v_q;
  logic            cursor_v_q;
  logic [KeyW-1:0] cursor_q;
  logic            above_cursor, below_best;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign kind     = kind_e'(kind_i);
  assign bad_cfg  = (cfg_q.min_amp == 32'd0) || (cfg_q.min_amp > cfg_q.max_amp);
  assign last_idx = IdxW'(count_q - CntW'(1));

  assign new_hit.primer = hit_primer_i;
  assign new_hit.strand = hit_strand_i;
  assign new_hit.pos    = hit_position_i;
  assign new_hit.mm     = hit_mismatches_i;
  assign new_hit.mask   = hit_mask_i;

  logic load_we;
  assign load_we = accept && (kind == KIND_LOAD) && (count_q < CntW'(HitEntries));

  // Two copies of the hit table: one read port for the forward hit, one for the reverse.
  ppaj_ram #(.Width($bits(hit_t)), .Depth(HitEntries)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (new_hit),
    .raddr_i (fi_q),
    .rdata_o (fwd_hit)
  );

  ppaj_ram #(.Width($bits(hit_t)), .Depth(HitEntries)) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (new_hit),
    .raddr_i (ri_q),
    .rdata_o (rev_hit)
  );

  ppaj_pair_unit u_pair (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_v_q),
    .fwd_i   (fwd_hit),
    .rev_i   (rev_hit),
    .cfg_i   (cfg_q),
    .valid_o (cand_v),
    .cand_o  (cand)
  );

  assign above_cursor = !cursor_v_q || (prod_key(cand) > cursor_q);
  assign below_best   = !best_v_q || (prod_key(cand) < prod_key(best_q));

  // Next state and control.
  always_comb begin
    state_d   = state_q;
    fetch_go  = 1'b0;
    issue_v   = 1'b0;
    scan_step = 1'b0;
    report    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (kind == KIND_FETCH) && !bad_cfg && !overflow_q) begin
          fetch_go = 1'b1;
          state_d  = (count_q == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue_v   = 1'b1;
        scan_step = 1'b1;
        if ((fi_q == last_idx) && (ri_q == last_idx)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !cand_v) begin
          report  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      overflow_q <= 1'b0;
      fi_q       <= '0;
      ri_q       <= '0;
      rd_v_q     <= 1'b0;
      best_v_q   <= 1'b0;
      cursor_v_q <= 1'b0;
      cursor_q   <= '0;
      done_o     <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue_v;
      done_o  <= report || (accept && (kind == KIND_FETCH) && (bad_cfg || overflow_q));

      if (accept && (kind == KIND_LOAD)) begin
        if (load_we) begin
          count_q <= count_q + CntW'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (accept && (kind == KIND_CLEAR)) begin
        count_q    <= '0;
        overflow_q <= 1'b0;
        cursor_v_q <= 1'b0;
        cursor_q   <= '0;
      end

      if (fetch_go) begin
        fi_q     <= '0;
        ri_q     <= '0;
        best_v_q <= 1'b0;
      end
      if (scan_step) begin
        if (ri_q == last_idx) begin
          ri_q <= '0;
          fi_q <= fi_q + IdxW'(1);
        end else begin
          ri_q <= ri_q + IdxW'(1);
        end
      end
      if (cand_v && above_cursor && below_best) begin
        best_v_q <= 1'b1;
      end
      if (report) begin
        if (best_v_q) begin
          cursor_v_q <= 1'b1;
          cursor_q   <= prod_key(best_q);
        end
      end
    end
  end

  // Best candidate payload and result payload.
  always_ff @(posedge clk_i) begin
    if (cand_v && above_cursor && below_best) begin
      best_q <= cand;
    end
    if (accept && (kind == KIND_FETCH) && (bad_cfg || overflow_q)) begin
      status_o           <= bad_cfg ? STATUS_BAD_CFG : STATUS_OVERFLOW;
      left_primer_o      <= 1'b0;
      right_primer_o     <= 1'b0;
      left_position_o    <= '0;
      right_position_o   <= '0;
      left_mismatches_o  <= '0;
      right_mismatches_o <= '0;
      amplicon_end_o     <= '0;
      amplicon_length_o  <= '0;
      left_mask_o        <= '0;
      right_mask_o       <= '0;
    end else if (report) begin
      if (best_v_q) begin
        status_o           <= STATUS_PRODUCT;
        left_primer_o      <= best_q.lp;
        right_primer_o     <= best_q.rp;
        left_position_o    <= best_q.start;
        right_position_o   <= best_q.rpos;
        left_mismatches_o  <= best_q.lmm;
        right_mismatches_o <= best_q.rmm;
        amplicon_end_o     <= best_q.amp_end;
        amplicon_length_o  <= best_q.len;
        left_mask_o        <= best_q.lmask;
        right_mask_o       <= best_q.rmask;
      end else begin
        status_o           <= STATUS_END;
        left_primer_o      <= 1'b0;
        right_primer_o     <= 1'b0;
        left_position_o    <= '0;
        right_position_o   <= '0;
        left_mismatches_o  <= '0;
        right_mismatches_o <= '0;
        amplicon_end_o     <= '0;
        amplicon_length_o  <= '0;
        left_mask_o        <= '0;
        right_mask_o       <= '0;
      end
    end
  end

endmodule
